@@ rtl/ppsf_pkg.sv @@
// Package for the path point spacing filter: field widths, the point record
// and the helpers that pack and unpack stream words.
// Depends on nothing; used by path_point_spacing_filter.
package ppsf_pkg;

  // Field widths
  localparam int COORD_BITS   = 31;
  localparam int QUAT_BITS    = 16;
  localparam int SPEED_BITS   = 32;
  localparam int KIND_BITS    = 8;
  localparam int SPACING_BITS = 16;
  localparam int LIM_BITS     = 2 * SPACING_BITS;
  localparam int DIFF_BITS    = COORD_BITS + 1;

  // Stream word layout
  localparam int DATA_BITS  = 3 * COORD_BITS + 4 * QUAT_BITS + SPEED_BITS;
  localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
  localparam int PAD_BITS   = TDATA_BITS - DATA_BITS;

  // Spacing reset is 10 mm, kept here already squared
  localparam logic [LIM_BITS-1:0] LIM_RESET = LIM_BITS'(10 * 10);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;
  localparam logic [CNT_BITS-1:0] FIFO_ROOM2 = CNT_BITS'(FIFO_DEPTH - 2);
  localparam logic [CNT_BITS-1:0] FIFO_FULL  = CNT_BITS'(FIFO_DEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic signed [QUAT_BITS-1:0]  qx;
    logic signed [QUAT_BITS-1:0]  qy;
    logic signed [QUAT_BITS-1:0]  qz;
    logic signed [QUAT_BITS-1:0]  qw;
    logic signed [SPEED_BITS-1:0] speed;
    logic [KIND_BITS-1:0]         kind;
    logic                         last;
  } point_t;

  // tdata: x, y, z, qx, qy, qz, qw, speed from the lowest bit up
  function automatic point_t unpack_point(input logic [TDATA_BITS-1:0] data,
                                          input logic [KIND_BITS-1:0]  kind,
                                          input logic                  last);
    point_t p;
    {p.speed, p.qw, p.qz, p.qy, p.qx, p.z, p.y, p.x} = data[DATA_BITS-1:0];
    p.kind = kind;
    p.last = last;
    return p;
  endfunction

  function automatic logic [TDATA_BITS-1:0] pack_point(input point_t p);
    return {{PAD_BITS{1'b0}}, p.speed, p.qw, p.qz, p.qy, p.qx, p.z, p.y, p.x};
  endfunction

endpackage

@@ rtl/path_point_spacing_filter.sv @@
// Path point spacing filter: top level, one-pass keep/merge logic and a
// small result queue. Depends on ppsf_pkg.
//
// The filter passes on only points that lie farther than the spacing register
// (in the x-y plane) from the last kept point; a point that is too close is
// dropped and its speed folded into the kept point as a signed minimum. The
// first point of a path is always kept, and the point with tlast set flushes
// the held point with tlast set. In the input register the distance test and
// the held point update are done in a single pass (two 16x16 squares, one add
// and one compare), so one path point is taken per cycle while the result
// queue has room. Results leave through a four-entry queue, one per cycle
// while the receiver is ready; since a kept last point after a held point
// yields two results, the input waits whenever the queue holds more than two
// results. A write on the cfg port sets the spacing in mm (reset 10); write
// it only while the block is idle.
module path_point_spacing_filter (
  input  logic                           clk,
  input  logic                           rst,
  // spacing register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppsf_pkg::SPACING_BITS-1:0] cfg_data,   // min_spacing_mm
  // input points
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ppsf_pkg::TDATA_BITS-1:0] s_axis_tdata,  // x, y, z, qx, qy, qz, qw, speed
  input  logic [ppsf_pkg::KIND_BITS-1:0]  s_axis_tuser,  // kind
  input  logic                           s_axis_tlast,
  // kept points
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ppsf_pkg::TDATA_BITS-1:0] m_axis_tdata,  // x, y, z, qx, qy, qz, qw, speed
  output logic [ppsf_pkg::KIND_BITS-1:0]  m_axis_tuser,  // kind
  output logic                           m_axis_tlast
);

  // Squared spacing, worked out once per register write
  logic [ppsf_pkg::LIM_BITS-1:0] lim_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_sq <= ppsf_pkg::LIM_RESET;
    end else if (cfg_valid) begin
      lim_sq <= ppsf_pkg::LIM_BITS'(cfg_data) * ppsf_pkg::LIM_BITS'(cfg_data);
    end
  end

  // Input register
  logic              s1_valid;
  ppsf_pkg::point_t  s1;
  logic              s1_fire;
  logic [ppsf_pkg::CNT_BITS-1:0] count;

  assign s1_fire       = s1_valid && (count <= ppsf_pkg::FIFO_ROOM2);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1 <= ppsf_pkg::unpack_point(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end

  // Held point
  logic              held_valid;
  ppsf_pkg::point_t  held;

  // Planar distance test
  logic signed [ppsf_pkg::DIFF_BITS-1:0]  dx, dy;
  logic [ppsf_pkg::DIFF_BITS-1:0]         adx, ady;
  logic [ppsf_pkg::LIM_BITS-1:0]          sqx, sqy;
  logic [ppsf_pkg::LIM_BITS:0]            sq_sum;
  logic                                   far;
  logic                                   keep;

  always_comb begin
    dx = ppsf_pkg::DIFF_BITS'(s1.x) - ppsf_pkg::DIFF_BITS'(held.x);
    dy = ppsf_pkg::DIFF_BITS'(s1.y) - ppsf_pkg::DIFF_BITS'(held.y);
    adx = dx[ppsf_pkg::DIFF_BITS-1] ? -dx : dx;
    ady = dy[ppsf_pkg::DIFF_BITS-1] ? -dy : dy;
    // any offset of 2^16 or more lies beyond the largest spacing
    far = (|adx[ppsf_pkg::DIFF_BITS-1:ppsf_pkg::SPACING_BITS]) ||
          (|ady[ppsf_pkg::DIFF_BITS-1:ppsf_pkg::SPACING_BITS]);
    sqx = ppsf_pkg::LIM_BITS'(adx[ppsf_pkg::SPACING_BITS-1:0]) *
          ppsf_pkg::LIM_BITS'(adx[ppsf_pkg::SPACING_BITS-1:0]);
    sqy = ppsf_pkg::LIM_BITS'(ady[ppsf_pkg::SPACING_BITS-1:0]) *
          ppsf_pkg::LIM_BITS'(ady[ppsf_pkg::SPACING_BITS-1:0]);
    sq_sum = {1'b0, sqx} + {1'b0, sqy};
    keep = !held_valid || far || (sq_sum > {1'b0, lim_sq});
  end

  // Results of this item: up to two pushes into the queue
  logic              push0, push1;
  ppsf_pkg::point_t  res0, res1;
  logic signed [ppsf_pkg::SPEED_BITS-1:0] min_speed;

  always_comb begin
    min_speed = (s1.speed < held.speed) ? s1.speed : held.speed;
    res1      = s1;
    res1.last = 1'b1;
    res0      = held;
    res0.last = 1'b0;
    push0     = 1'b0;
    push1     = 1'b0;
    if (keep && held_valid) begin
      push0 = s1_fire;
      push1 = s1_fire && s1.last;
    end else if (keep) begin
      res0  = res1;
      push0 = s1_fire && s1.last;
    end else begin
      res0.speed = min_speed;
      res0.last  = 1'b1;
      push0      = s1_fire && s1.last;
    end
  end

  // Held point update
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s1_fire) begin
      held_valid <= !s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (keep) begin
        held <= s1;
      end else begin
        held.speed <= min_speed;
      end
    end
  end

  // Result queue
  ppsf_pkg::point_t                fifo_mem [ppsf_pkg::FIFO_DEPTH];
  logic [ppsf_pkg::PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic                            pop;
  logic [ppsf_pkg::CNT_BITS-1:0]   n_push;

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign n_push = ppsf_pkg::CNT_BITS'(push0) + ppsf_pkg::CNT_BITS'(push1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ppsf_pkg::PTR_BITS'(n_push);
      rd_ptr <= rd_ptr + ppsf_pkg::PTR_BITS'(pop);
      count  <= count + n_push - ppsf_pkg::CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (push1) begin
      fifo_mem[wr_ptr + ppsf_pkg::PTR_BITS'(1)] <= res1;
    end
  end

  // Output side
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = ppsf_pkg::pack_point(fifo_mem[rd_ptr]);
  assign m_axis_tuser  = fifo_mem[rd_ptr].kind;
  assign m_axis_tlast  = fifo_mem[rd_ptr].last;

`ifndef SYNTH
  // Queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ppsf_pkg::FIFO_FULL)
    else $error("result queue overflow");

  // Two results only when a point was already held
  a_two_needs_held: assert property (@(posedge clk) disable iff (rst)
    push1 |-> (held_valid && push0))
    else $error("second result without held point");

  // A last item leaves nothing held
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1.last) |=> !held_valid)
    else $error("held point survives path end");

  // Every last item produces a flush result marked last
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1.last) |-> ((push1 && res1.last) || (!push1 && push0 && res0.last)))
    else $error("path end without flush");
`endif

endmodule

@@ test/path_point_spacing_filter_tb.sv @@
// Testbench for path_point_spacing_filter: directed and random path streams
// checked against a built-in keep/merge predictor of the spacing filter.
// Depends on ppsf_pkg and the filter RTL.
`timescale 1ns / 1ps

module path_point_spacing_filter_tb;

  localparam int  RANDOM_ITEMS  = 1150;
  localparam int  PHASES        = 8;
  localparam int  SETTLE_CYCLES = 6;
  localparam int  MAX_REPORTS   = 10;
  localparam longint CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  // DUT inputs all start at known values
  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [ppsf_pkg::SPACING_BITS-1:0] cfg_data = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ppsf_pkg::TDATA_BITS-1:0]   s_axis_tdata = '0;   // x, y, z, qx, qy, qz, qw, speed
  logic [ppsf_pkg::KIND_BITS-1:0]    s_axis_tuser = '0;   // kind
  logic                              s_axis_tlast = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ppsf_pkg::TDATA_BITS-1:0]   m_axis_tdata;        // x, y, z, qx, qy, qz, qw, speed
  logic [ppsf_pkg::KIND_BITS-1:0]    m_axis_tuser;        // kind
  logic                              m_axis_tlast;

  // Predictor state: spacing, the held point and the results still due
  logic [ppsf_pkg::SPACING_BITS-1:0] spacing_mm = ppsf_pkg::SPACING_BITS'(10);
  ppsf_pkg::point_t                  held_point;
  bit                                holding = 1'b0;
  ppsf_pkg::point_t                  kept_points[$];

  // Run statistics
  int     items_sent = 0;
  int     results_seen = 0;
  int     mismatches = 0;
  int     keeps = 0;
  int     merges = 0;
  int     paths = 0;
  int     spacing_writes = 0;
  longint cycles = 0;

  // Flow control knobs
  sink_mode_t sink_mode = SINK_FREE;
  logic [7:0] sink_pattern = 8'hFF;
  bit         sender_gaps = 1'b0;
  int         burst_left = 0;

  path_point_spacing_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Keep/merge decision for one accepted point; queues the released points
  function automatic void space_point(input ppsf_pkg::point_t p);
    longint            dx, dy;
    longint unsigned   dist2, lim;
    bit                keep;
    ppsf_pkg::point_t  r;
    keep = 1'b1;
    if (holding) begin
      dx = $signed(p.x) - $signed(held_point.x);
      dy = $signed(p.y) - $signed(held_point.y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      // both squares stay below 2^62, so the sum cannot wrap
      dist2 = longint'(dx * dx) + longint'(dy * dy);
      lim = longint'(spacing_mm) * longint'(spacing_mm);
      keep = dist2 > lim;
    end
    if (keep) begin
      if (holding) begin
        r = held_point;
        r.last = 1'b0;
        kept_points.insert(kept_points.size(), r);
      end
      held_point = p;
      holding = 1'b1;
      keeps++;
    end else begin
      merges++;
      if ($signed(p.speed) < $signed(held_point.speed)) held_point.speed = p.speed;
    end
    // end of path: flush whatever is held
    if (p.last) begin
      r = held_point;
      r.last = 1'b1;
      kept_points.insert(kept_points.size(), r);
      holding = 1'b0;
      paths++;
    end
  endfunction

  // Point at a given planar position and last flag, everything else random
  function automatic ppsf_pkg::point_t point_at(input longint x, input longint y,
                                                input bit last);
    ppsf_pkg::point_t p;
    p.x     = x[ppsf_pkg::COORD_BITS-1:0];
    p.y     = y[ppsf_pkg::COORD_BITS-1:0];
    p.z     = ppsf_pkg::COORD_BITS'($urandom());
    p.qx    = ppsf_pkg::QUAT_BITS'($urandom());
    p.qy    = ppsf_pkg::QUAT_BITS'($urandom());
    p.qz    = ppsf_pkg::QUAT_BITS'($urandom());
    p.qw    = ppsf_pkg::QUAT_BITS'($urandom());
    p.speed = $urandom();
    p.kind  = ppsf_pkg::KIND_BITS'($urandom());
    p.last  = last;
    return p;
  endfunction

  function automatic void show_point(input string tag, input ppsf_pkg::point_t p);
    $display("  %s x=%0d y=%0d z=%0d q=(%0d %0d %0d %0d) speed=%0d kind=%0d last=%0b",
             tag, p.x, p.y, p.z, p.qx, p.qy, p.qz, p.qw, p.speed, p.kind, p.last);
  endfunction

  // Send one item; bursts of random length, with random gaps between them when sender_gaps is set
  task automatic send_point(input ppsf_pkg::point_t p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_gaps) gap = $urandom_range(0, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{ppsf_pkg::PAD_BITS{1'b0}}, p.speed, p.qw, p.qz, p.qy, p.qx,
                      p.z, p.y, p.x};
    s_axis_tuser  <= p.kind;
    s_axis_tlast  <= p.last;
    do @(posedge clk); while (!s_axis_tready);
    space_point(p);
    items_sent++;
  endtask

  // Stop sending and wait until every due result is out and the pipe is empty
  task automatic settle_filter();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (kept_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [ppsf_pkg::SPACING_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    spacing_mm = value;
    spacing_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset spacing of 10: lone point, merges, exact boundary, keep, flushes
  task automatic test_merge_and_keep();
    ppsf_pkg::point_t p;
    send_point(point_at(0, 0, 1'b1));
    p = point_at(0, 0, 1'b0);
    p.speed = 100;
    send_point(p);
    p = point_at(5, 5, 1'b0);
    p.speed = 50;
    send_point(p);
    // distance exactly 10 is not greater than the spacing
    p = point_at(10, 0, 1'b0);
    p.speed = 70;
    send_point(p);
    send_point(point_at(11, 0, 1'b0));
    send_point(point_at(11, 3, 1'b1));
    // kept last point gives a release and a flush
    send_point(point_at(-7, -7, 1'b0));
    send_point(point_at(100, -100, 1'b1));
    settle_filter();
  endtask

  // Field extremes and the largest planar distance
  task automatic test_field_extremes();
    ppsf_pkg::point_t p;
    p = point_at(-1073741824, -1073741824, 1'b0);
    p.z = {1'b1, {(ppsf_pkg::COORD_BITS-1){1'b0}}};
    p.qx = 16'h8000; p.qy = 16'h8000; p.qz = 16'h8000; p.qw = 16'h8000;
    p.speed = 32'h8000_0000;
    p.kind = '0;
    send_point(p);
    p = point_at(-1073741824, -1073741824, 1'b0);
    p.z = {1'b0, {(ppsf_pkg::COORD_BITS-1){1'b1}}};
    p.qx = 16'h7FFF; p.qy = 16'h7FFF; p.qz = 16'h7FFF; p.qw = 16'h7FFF;
    p.speed = 32'h7FFF_FFFF;
    p.kind = '1;
    send_point(p);
    p.x = {1'b0, {(ppsf_pkg::COORD_BITS-1){1'b1}}};
    p.y = {1'b0, {(ppsf_pkg::COORD_BITS-1){1'b1}}};
    p.last = 1'b1;
    send_point(p);
    p = point_at(1073741823, -1073741824, 1'b1);
    p.speed = 32'h8000_0000;
    send_point(p);
    settle_filter();
  endtask

  // Zero spacing: same x-y merges, any offset keeps
  task automatic test_zero_spacing();
    ppsf_pkg::point_t p;
    write_spacing('0);
    p = point_at(3, 3, 1'b0);
    p.speed = 32'h7FFF_FFFF;
    send_point(p);
    p = point_at(3, 3, 1'b0);
    p.speed = 32'h8000_0000;
    send_point(p);
    send_point(point_at(3, 4, 1'b0));
    send_point(point_at(2, 4, 1'b1));
    settle_filter();
  endtask

  // Widest spacing: squared distances past 32 bits against the largest squared limit
  task automatic test_wide_spacing();
    write_spacing('1);
    send_point(point_at(0, 0, 1'b0));
    send_point(point_at(65535, 0, 1'b0));
    send_point(point_at(0, -65535, 1'b0));
    send_point(point_at(46341, 46341, 1'b0));
    send_point(point_at(46341 + 65536, 46341, 1'b1));
    settle_filter();
  endtask

  // Random paths over several spacing settings and flow-control modes
  task automatic test_random_paths();
    logic [ppsf_pkg::SPACING_BITS-1:0] plan [PHASES];
    int     quota, phase_items, len;
    longint x, y, reach;
    plan[0] = 16'd10;
    plan[1] = 16'd1;
    plan[2] = 16'd0;
    plan[3] = ppsf_pkg::SPACING_BITS'($urandom_range(2, 300));
    plan[4] = 16'hFFFF;
    plan[5] = ppsf_pkg::SPACING_BITS'($urandom_range(0, 65535));
    plan[6] = ppsf_pkg::SPACING_BITS'($urandom_range(1000, 20000));
    plan[7] = 16'd10;
    quota = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_filter();
      write_spacing(plan[ph]);
      // first phase runs with no idling at all
      sink_mode    = sink_mode_t'(ph % 3);
      sender_gaps  = (ph != 0) && (ph != 5);
      sink_pattern = 8'($urandom_range(1, 255));
      reach = 2 * longint'(plan[ph]) + 2;
      phase_items = 0;
      while (phase_items < quota) begin
        len = $urandom_range(1, 24);
        // last path of a phase is cut to fit the quota
        if (len > quota - phase_items) len = quota - phase_items;
        if ($urandom_range(0, 9) == 0) begin
          x = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 1073741824;
          y = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 1073741824;
        end else begin
          x = longint'($urandom_range(0, 2000000)) - 1000000;
          y = longint'($urandom_range(0, 2000000)) - 1000000;
        end
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            case ($urandom_range(0, 19))
              0: begin
                // stray point anywhere in the plane
                x = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 1073741824;
                y = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 1073741824;
              end
              1: x = x + longint'(plan[ph]);          // right on the spacing
              2: y = y - longint'(plan[ph]) - 1;      // just past it
              default: begin
                x = x + longint'($urandom_range(0, 32'(2 * reach))) - reach;
                y = y + longint'($urandom_range(0, 32'(2 * reach))) - reach;
              end
            endcase
          end
          send_point(point_at(x, y, i == len - 1));
          phase_items++;
        end
      end
    end
    settle_filter();
  endtask

  // Receiver side: free, random or a rotating stall pattern
  always @(negedge clk) begin
    case (sink_mode)
      SINK_FREE:    m_axis_tready <= 1'b1;
      SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      SINK_PATTERN: begin
        m_axis_tready <= sink_pattern[0];
        sink_pattern  <= {sink_pattern[0], sink_pattern[7:1]};
      end
      default:      m_axis_tready <= 1'b1;
    endcase
  end

  // Compare each result with the oldest due point
  always @(posedge clk) begin
    ppsf_pkg::point_t got, want;
    string            bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      {got.speed, got.qw, got.qz, got.qy, got.qx, got.z, got.y, got.x} =
        m_axis_tdata[ppsf_pkg::DATA_BITS-1:0];
      got.kind = m_axis_tuser;
      got.last = m_axis_tlast;
      results_seen++;
      if (kept_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with nothing due", $realtime);
          show_point("got ", got);
        end
      end else begin
        want = kept_points.pop_front();
        bad = "";
        if (got.x !== want.x)         bad = {bad, " x"};
        if (got.y !== want.y)         bad = {bad, " y"};
        if (got.z !== want.z)         bad = {bad, " z"};
        if (got.qx !== want.qx)       bad = {bad, " qx"};
        if (got.qy !== want.qy)       bad = {bad, " qy"};
        if (got.qz !== want.qz)       bad = {bad, " qz"};
        if (got.qw !== want.qw)       bad = {bad, " qw"};
        if (got.speed !== want.speed) bad = {bad, " speed"};
        if (got.kind !== want.kind)   bad = {bad, " kind"};
        if (got.last !== want.last)   bad = {bad, " last"};
        if (m_axis_tdata[ppsf_pkg::TDATA_BITS-1:ppsf_pkg::DATA_BITS] !== '0) begin
          bad = {bad, " pad"};
        end
        if (bad != "") begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result %0d differs in%s", $realtime, results_seen, bad);
            show_point("want", want);
            show_point("got ", got);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               kept_points.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_merge_and_keep();
    test_field_extremes();
    test_zero_spacing();
    test_wide_spacing();
    test_random_paths();
    $display("%0d points in %0d paths (%0d kept, %0d merged), %0d results checked",
             items_sent, paths, keeps, merges, results_seen);
    $display("%0d spacing writes from 0 to 65535, %0d mismatches, %0d cycles",
             spacing_writes, mismatches, cycles);
    if (mismatches == 0 && kept_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
